// ===== hdl/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants of the looping sample player.
// ----------------------------------------------------------------------------
package lsp_pkg;

    localparam int MAX_FRAMES_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int GAIN_W  = 16;
    localparam int DELAY_W = 24;
    localparam int PASS_W  = 16;
    localparam int FUNC_W  = 3;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [GAIN_W-1:0]  GAIN_UNITY  = 16'd16384;
    localparam logic [DELAY_W-1:0] DELAY_RESET = '0;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD     = 3'd0,
        FN_TICK     = 3'd1,
        FN_PLAY     = 3'd2,
        FN_STOP     = 3'd3,
        FN_RESET    = 3'd4,
        FN_SET_LOOP = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        REG_LENGTH = 3'd0,
        REG_DELAY  = 3'd1,
        REG_LGAIN  = 3'd2,
        REG_RGAIN  = 3'd3,
        REG_MONO   = 3'd4
    } reg_index_t;

    // configuration fields of fixed width
    typedef struct packed {
        logic [DELAY_W-1:0] loop_delay_frames;
        logic [GAIN_W-1:0]  left_gain;
        logic [GAIN_W-1:0]  right_gain;
        logic               source_is_mono;
    } cfg_t;

    // per-item control outcome, carried alongside the RAM read
    typedef struct packed {
        logic              play;
        logic              delay_flag;
        logic              active;
        logic [PASS_W-1:0] passes;
    } tick_info_t;

endpackage

// ===== hdl/looping_sample_player.sv =====
// ----------------------------------------------------------------------------
// looping_sample_player
// Stored-sound playback voice with loop delay, pass count and stereo gain.
// ----------------------------------------------------------------------------
// One item per clock while the output is not stalled, one result per item.
// The input transfer loads stage one with the registered RAM read and the
// control outcome; the result register loads from stage one, through the
// gain multiply, when the output can advance. Playback state advances at
// the input transfer and addresses the sound RAM. Stage one and the result
// register decouple the sides, so one item can enter stage one while a result waits.
// The sound RAM has no reset; frames must be loaded before they are played.
// ----------------------------------------------------------------------------
module looping_sample_player #(
    parameter int MAX_FRAMES  = lsp_pkg::MAX_FRAMES_DEF,
    parameter int SAMPLE_BITS = lsp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lsp_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [lsp_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [lsp_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    // input items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lsp_pkg::FUNC_W-1:0]           s_func,
    input  logic [$clog2(MAX_FRAMES)-1:0]        s_load_address,
    input  logic signed [SAMPLE_BITS-1:0]        s_load_left,
    input  logic signed [SAMPLE_BITS-1:0]        s_load_right,
    input  logic                                 s_loop_enable,
    // results
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_BITS-1:0]        m_left_out,
    output logic signed [SAMPLE_BITS-1:0]        m_right_out,
    output logic                                 m_active,
    output logic                                 m_in_delay,
    output logic [lsp_pkg::PASS_W-1:0]           m_passes_done
);

    localparam int ADDR_W = $clog2(MAX_FRAMES);
    localparam int LEN_W  = $clog2(MAX_FRAMES + 1);

    logic [LEN_W-1:0]    sample_length;
    lsp_pkg::cfg_t       cfg;
    logic [ADDR_W-1:0]   rd_addr;
    lsp_pkg::tick_info_t info;

    logic                s_fire;
    logic                advance;
    logic                load_we;
    logic [2*SAMPLE_BITS-1:0] rd_data;

    logic                v1_reg;
    lsp_pkg::tick_info_t info1_reg;

    logic signed [SAMPLE_BITS-1:0] left_src, right_src;
    logic signed [SAMPLE_BITS-1:0] left_scaled, right_scaled;

    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] left_reg, right_reg;
    logic                          active_reg, in_delay_reg;
    logic [lsp_pkg::PASS_W-1:0]    passes_reg;

    lsp_regs #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .sample_length (sample_length),
        .cfg           (cfg)
    );

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !v1_reg || advance;
    assign s_fire  = s_valid && s_ready;

    lsp_ctrl #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (s_fire),
        .func          (s_func),
        .loop_enable   (s_loop_enable),
        .sample_length (sample_length),
        .cfg           (cfg),
        .rd_addr       (rd_addr),
        .info          (info)
    );

    assign load_we = s_fire && (s_func == lsp_pkg::FN_LOAD) &&
                     (32'(s_load_address) < 32'(MAX_FRAMES));

    lsp_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_store (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (s_load_address),
        .wdata ({s_load_left, s_load_right}),
        .re    (s_fire),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // stage one: control outcome waits with the RAM read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_fire) begin
            v1_reg <= 1'b1;
        end else if (advance) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            info1_reg <= info;
        end
    end

    assign left_src  = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign right_src = cfg.source_is_mono ? left_src : rd_data[SAMPLE_BITS-1:0];

    lsp_scale #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_scale_l (
        .sample (left_src),
        .gain   (cfg.left_gain),
        .scaled (left_scaled)
    );

    lsp_scale #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_scale_r (
        .sample (right_src),
        .gain   (cfg.right_gain),
        .scaled (right_scaled)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && v1_reg) begin
            left_reg     <= info1_reg.play ? left_scaled : '0;
            right_reg    <= info1_reg.play ? right_scaled : '0;
            active_reg   <= info1_reg.active;
            in_delay_reg <= info1_reg.delay_flag;
            passes_reg   <= info1_reg.passes;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_left_out    = left_reg;
    assign m_right_out   = right_reg;
    assign m_active      = active_reg;
    assign m_in_delay    = in_delay_reg;
    assign m_passes_done = passes_reg;

`ifndef SYNTH
    // a delay frame leaves the player running
    a_delay_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_delay |-> m_active)
        else $error("delay frame reported while inactive");

    // backpressure only with stage one occupied
    a_ready_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1_reg && m_valid_reg && !m_ready)
        else $error("input stalled with free pipeline");

    // a reset event clears the pass count and stops playback
    a_reset_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_func == lsp_pkg::FN_RESET |=>
            v1_reg && !info1_reg.active && info1_reg.passes == '0)
        else $error("reset event did not clear playback state");

    // silence and no delay flag for non-tick items
    a_nontick_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_func != lsp_pkg::FN_TICK |=>
            !info1_reg.play && !info1_reg.delay_flag)
        else $error("non-tick item produced a frame");
`endif

endmodule

// ===== hdl/lsp_ram.sv =====
// ----------------------------------------------------------------------------
// lsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/lsp_regs.sv =====
// ----------------------------------------------------------------------------
// lsp_regs
// APB configuration registers: length, loop delay, gains, mono select.
// ----------------------------------------------------------------------------
module lsp_regs #(
    parameter int MAX_FRAMES = lsp_pkg::MAX_FRAMES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lsp_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [lsp_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [lsp_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready,
    output logic [$clog2(MAX_FRAMES+1)-1:0]       sample_length,
    output lsp_pkg::cfg_t                         cfg
);

    localparam int LEN_W = $clog2(MAX_FRAMES + 1);

    logic [LEN_W-1:0] length_reg;
    lsp_pkg::cfg_t    cfg_reg;
    logic [2:0]       index;
    logic             wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg                <= LEN_W'(MAX_FRAMES);
            cfg_reg.loop_delay_frames <= lsp_pkg::DELAY_RESET;
            cfg_reg.left_gain         <= lsp_pkg::GAIN_UNITY;
            cfg_reg.right_gain        <= lsp_pkg::GAIN_UNITY;
            cfg_reg.source_is_mono    <= 1'b0;
        end else if (wr_en) begin
            unique case (index)
                lsp_pkg::REG_LENGTH: length_reg <= pwdata[LEN_W-1:0];
                lsp_pkg::REG_DELAY:
                    cfg_reg.loop_delay_frames <= pwdata[lsp_pkg::DELAY_W-1:0];
                lsp_pkg::REG_LGAIN:  cfg_reg.left_gain <= pwdata[lsp_pkg::GAIN_W-1:0];
                lsp_pkg::REG_RGAIN:  cfg_reg.right_gain <= pwdata[lsp_pkg::GAIN_W-1:0];
                lsp_pkg::REG_MONO:   cfg_reg.source_is_mono <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (index)
            lsp_pkg::REG_LENGTH: prdata = lsp_pkg::APB_DATA_W'(length_reg);
            lsp_pkg::REG_DELAY:  prdata = lsp_pkg::APB_DATA_W'(cfg_reg.loop_delay_frames);
            lsp_pkg::REG_LGAIN:  prdata = lsp_pkg::APB_DATA_W'(cfg_reg.left_gain);
            lsp_pkg::REG_RGAIN:  prdata = lsp_pkg::APB_DATA_W'(cfg_reg.right_gain);
            lsp_pkg::REG_MONO:   prdata = lsp_pkg::APB_DATA_W'(cfg_reg.source_is_mono);
            default:             prdata = '0;
        endcase
    end

    assign sample_length = length_reg;
    assign cfg           = cfg_reg;

endmodule

// ===== hdl/lsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsp_ctrl
// Playback state: position, loop delay, run/end flags and pass count.
// Updates at each accepted item and issues the store read address.
// ----------------------------------------------------------------------------
module lsp_ctrl #(
    parameter int MAX_FRAMES = lsp_pkg::MAX_FRAMES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              fire,
    input  logic [lsp_pkg::FUNC_W-1:0]        func,
    input  logic                              loop_enable,
    input  logic [$clog2(MAX_FRAMES+1)-1:0]   sample_length,
    input  lsp_pkg::cfg_t                     cfg,
    output logic [$clog2(MAX_FRAMES)-1:0]     rd_addr,
    output lsp_pkg::tick_info_t               info
);

    localparam int ADDR_W = $clog2(MAX_FRAMES);
    localparam int LEN_W  = $clog2(MAX_FRAMES + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAMES);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    logic [ADDR_W-1:0]          pos_reg, pos_next;
    logic [lsp_pkg::DELAY_W-1:0] delay_reg, delay_next;
    logic                       looping_reg, looping_next;
    logic                       running_reg, running_next;
    logic                       ended_reg, ended_next;
    logic [lsp_pkg::PASS_W-1:0] pass_reg, pass_next;

    logic [LEN_W-1:0]  len_eff;
    logic [ADDR_W-1:0] pos_eff;
    logic [LEN_W-1:0]  pos_inc;
    logic              play;
    logic              delay_flag;

    always_comb begin
        if (sample_length == '0) begin
            len_eff = LEN_ONE;
        end else if (sample_length > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = sample_length;
        end
        // shrunk length below the position plays from frame 0
        pos_eff = (LEN_W'(pos_reg) >= len_eff) ? '0 : pos_reg;
        pos_inc = LEN_W'(pos_eff) + LEN_ONE;
    end

    always_comb begin
        pos_next     = pos_reg;
        delay_next   = delay_reg;
        looping_next = looping_reg;
        running_next = running_reg;
        ended_next   = ended_reg;
        pass_next    = pass_reg;
        play         = 1'b0;
        delay_flag   = 1'b0;
        unique case (func)
            lsp_pkg::FN_TICK: begin
                if (running_reg && !ended_reg) begin
                    if (looping_reg && delay_reg != '0) begin
                        delay_next = delay_reg - 1'b1;
                        delay_flag = 1'b1;
                    end else begin
                        play = 1'b1;
                        if (pos_inc >= len_eff) begin
                            pos_next = '0;
                            if (looping_reg) begin
                                pass_next  = pass_reg + 1'b1;
                                delay_next = cfg.loop_delay_frames;
                            end else begin
                                ended_next = 1'b1;
                            end
                        end else begin
                            pos_next = pos_inc[ADDR_W-1:0];
                        end
                    end
                end
            end
            lsp_pkg::FN_PLAY: running_next = 1'b1;
            lsp_pkg::FN_STOP: running_next = 1'b0;
            lsp_pkg::FN_RESET: begin
                pos_next     = '0;
                delay_next   = '0;
                running_next = 1'b0;
                ended_next   = 1'b0;
                pass_next    = '0;
            end
            lsp_pkg::FN_SET_LOOP: begin
                looping_next = loop_enable;
                // leaving a delay early ends the stream
                if (delay_reg != '0) begin
                    delay_next = '0;
                    ended_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            delay_reg   <= '0;
            looping_reg <= 1'b0;
            running_reg <= 1'b0;
            ended_reg   <= 1'b0;
            pass_reg    <= '0;
        end else if (fire) begin
            pos_reg     <= pos_next;
            delay_reg   <= delay_next;
            looping_reg <= looping_next;
            running_reg <= running_next;
            ended_reg   <= ended_next;
            pass_reg    <= pass_next;
        end
    end

    assign rd_addr         = pos_eff;
    assign info.play       = play;
    assign info.delay_flag = delay_flag;
    assign info.active     = running_next && !ended_next;
    assign info.passes     = pass_next;

endmodule

// ===== hdl/lsp_scale.sv =====
// ----------------------------------------------------------------------------
// lsp_scale
// Q2.14 gain: multiply, round half up, floor shift, saturate.
// ----------------------------------------------------------------------------
module lsp_scale #(
    parameter int SAMPLE_BITS = lsp_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0]    sample,
    input  logic [lsp_pkg::GAIN_W-1:0]       gain,
    output logic signed [SAMPLE_BITS-1:0]    scaled
);

    localparam int P = SAMPLE_BITS + lsp_pkg::GAIN_W + 1;
    localparam logic signed [P-1:0] HI   = P'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [P-1:0] LO   = -HI - P'(1);
    localparam logic signed [P-1:0] HALF = P'(8192);

    logic signed [P-1:0] sample_ext;
    logic signed [P-1:0] gain_ext;
    logic signed [P-1:0] prod;
    logic signed [P-1:0] rounded;
    logic signed [P-1:0] q;

    assign sample_ext = {{(P-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
    assign gain_ext   = {{(P-lsp_pkg::GAIN_W){1'b0}}, gain};
    assign prod       = sample_ext * gain_ext;
    assign rounded    = prod + HALF;
    assign q          = rounded >>> 14;

    always_comb begin
        if (q > HI) begin
            scaled = HI[SAMPLE_BITS-1:0];
        end else if (q < LO) begin
            scaled = LO[SAMPLE_BITS-1:0];
        end else begin
            scaled = q[SAMPLE_BITS-1:0];
        end
    end

endmodule
